[hw/rtl/swb_pkg.sv]
// shared types and constants of the swept box collision core
package swb_pkg;

   // stream word widths
   localparam int REQ_W = 160;
   localparam int RSP_W = 64;

   // datapath widths
   localparam int NUM_W = 18;
   localparam int MAG_W = 17;
   localparam int DVD_W = 33;
   localparam int DIV_W = 16;
   localparam int T_W   = 42;
   localparam int ACC_W = 52;
   localparam int LANES = 4;

   // divider: three quotient bits per stage
   localparam int DIV_STEPS  = 3;
   localparam int DIV_STAGES = DVD_W / DIV_STEPS;

   // stage numbers after the divider
   localparam int ST_TIME = DIV_STAGES + 1;
   localparam int ST_SWAP = DIV_STAGES + 2;
   localparam int ST_SEL  = DIV_STAGES + 3;
   localparam int ST_MUL  = DIV_STAGES + 4;
   localparam int ST_ACC  = DIV_STAGES + 5;
   localparam int ST_OUT  = DIV_STAGES + 6;
   localparam int N_ST    = DIV_STAGES + 7;

   // slab lanes
   localparam int LN_NX = 0;
   localparam int LN_NY = 1;
   localparam int LN_FX = 2;
   localparam int LN_FY = 3;

   // time constants, Q26.16
   localparam logic signed [T_W-1:0] T_INF = 42'sh100_0000_0000;
   localparam logic signed [T_W-1:0] T_ONE = 42'sd65536;
   localparam logic signed [T_W-1:0] T_LOW = -42'sd6;

   // normal codes
   localparam logic signed [1:0] NRM_POS = 2'sb01;
   localparam logic signed [1:0] NRM_NEG = 2'sb11;
   localparam logic signed [1:0] NRM_NONE = 2'sb00;

   typedef struct packed {
      logic signed [NUM_W-1:0] ox;
      logic signed [NUM_W-1:0] oy;
      logic signed [15:0]      vx;
      logic signed [15:0]      vy;
      logic                    zz;
   } hdr_type;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
      logic [DVD_W-1:0] quo;
      logic [DIV_W-1:0] d;
      logic             neg;
      logic             numneg;
      logic             vzero;
   } lane_type;

   typedef lane_type [LANES-1:0] div_type;

   typedef struct packed {
      logic signed [T_W-1:0] tnear;
      logic                  xgt;
      logic                  rej;
   } sel_type;

   typedef struct packed {
      logic signed [T_W-1:0] tnear;
      logic                  xgt;
      logic                  rej;
      logic                  tinf;
      logic signed [33:0]    pxl;
      logic signed [32:0]    pxh;
      logic signed [33:0]    pyl;
      logic signed [32:0]    pyh;
   } mul_type;

   typedef struct packed {
      logic signed [T_W-1:0]   tnear;
      logic                    xgt;
      logic                    rej;
      logic                    tinf;
      logic signed [ACC_W-1:0] accx;
      logic signed [ACC_W-1:0] accy;
   } acc_type;

endpackage

[hw/rtl/swept_box_collision_core.sv]
// swept box against still box test, pipelined slab divider and contact point
// takes one word per cycle unless the full pipe is stalled at the output; the depth is
// set by an entry stage and the four slab dividers, eleven stages of three quotient
// bits each, followed by six datapath stages
// each stage holds its word until the next one frees, bubbles close up on a stall
// reset clears every stage valid bit; payload registers are not reset
module swept_box_collision_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // source_x, source_y, source_w, source_h, vel_x, vel_y,
   // target_x, target_y, target_w, target_h, zero pad
   input  logic [swb_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // hit, contact_x, contact_y, normal_x, normal_y, entry_time, zero pad
   output logic [swb_pkg::RSP_W-1:0]  rsp_tdata
);

   // one restoring division step
   function automatic swb_pkg::lane_type div_step(swb_pkg::lane_type l);
      logic [swb_pkg::DIV_W:0] r;
      swb_pkg::lane_type o;
      o = l;
      r = {l.rem, l.dvd[swb_pkg::DVD_W-1]};
      o.dvd = {l.dvd[swb_pkg::DVD_W-2:0], 1'b0};
      if (r >= {1'b0, l.d}) begin
         o.rem = swb_pkg::DIV_W'(r - {1'b0, l.d});
         o.quo = {l.quo[swb_pkg::DVD_W-2:0], 1'b1};
      end else begin
         o.rem = r[swb_pkg::DIV_W-1:0];
         o.quo = {l.quo[swb_pkg::DVD_W-2:0], 1'b0};
      end
      return o;
   endfunction

   // saturate a contact accumulator to Q12.4
   function automatic logic signed [15:0] sat16(logic signed [swb_pkg::ACC_W-1:0] a);
      logic signed [swb_pkg::ACC_W-1:0] s;
      s = a >>> 16;
      if (s > swb_pkg::ACC_W'(32767))
         return 16'sh7FFF;
      else if (s < -swb_pkg::ACC_W'(32768))
         return 16'sh8000;
      else
         return s[15:0];
   endfunction

   logic [swb_pkg::N_ST-1:0] v_ff;
   logic [swb_pkg::N_ST-1:0] load;

   swb_pkg::hdr_type hdr_ff [0:swb_pkg::ST_OUT-1];
   swb_pkg::hdr_type hdr_in;
   swb_pkg::div_type div_ff [0:swb_pkg::DIV_STAGES];
   swb_pkg::div_type div_in;
   logic signed [swb_pkg::T_W-1:0] t_ff [swb_pkg::LANES];
   logic signed [swb_pkg::T_W-1:0] t_in [swb_pkg::LANES];
   logic signed [swb_pkg::T_W-1:0] s_ff [swb_pkg::LANES];
   logic signed [swb_pkg::T_W-1:0] s_in [swb_pkg::LANES];
   swb_pkg::sel_type sel_ff, sel_in;
   swb_pkg::mul_type mul_ff, mul_in;
   swb_pkg::acc_type acc_ff, acc_in;
   logic [swb_pkg::RSP_W-1:0] out_ff, out_in;

   // stage enables, a stage loads when empty or when its word moves on
   always_comb begin
      load[swb_pkg::N_ST-1] = !v_ff[swb_pkg::N_ST-1] || rsp_tready;
      for (int k = swb_pkg::N_ST - 2; k >= 0; k--)
         load[k] = !v_ff[k] || load[k+1];
   end

   assign req_tready = load[0];
   assign rsp_tvalid = v_ff[swb_pkg::N_ST-1];
   assign rsp_tdata  = out_ff;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (load[0])
            v_ff[0] <= req_tvalid;
         for (int k = 1; k < swb_pkg::N_ST; k++)
            if (load[k])
               v_ff[k] <= v_ff[k-1];
      end
   end

   // unpack word, slab numerators and divider operands
   always_comb begin
      logic signed [15:0] sx, sy, vx, vy, tx, ty;
      logic [14:0] sw, sh, tw, th;
      logic signed [swb_pkg::NUM_W-1:0] num [swb_pkg::LANES];
      logic signed [15:0] vl;
      logic [swb_pkg::NUM_W-1:0] mag;
      logic zz;
      sx = req_tdata[15:0];
      sy = req_tdata[31:16];
      sw = req_tdata[46:32];
      sh = req_tdata[61:47];
      vx = req_tdata[77:62];
      vy = req_tdata[93:78];
      tx = req_tdata[109:94];
      ty = req_tdata[125:110];
      tw = req_tdata[140:126];
      th = req_tdata[155:141];
      num[swb_pkg::LN_NX] = swb_pkg::NUM_W'(tx) - swb_pkg::NUM_W'(sx) - swb_pkg::NUM_W'(sw);
      num[swb_pkg::LN_NY] = swb_pkg::NUM_W'(ty) - swb_pkg::NUM_W'(sy) - swb_pkg::NUM_W'(sh);
      num[swb_pkg::LN_FX] = swb_pkg::NUM_W'(tx) + swb_pkg::NUM_W'(tw) - swb_pkg::NUM_W'(sx);
      num[swb_pkg::LN_FY] = swb_pkg::NUM_W'(ty) + swb_pkg::NUM_W'(th) - swb_pkg::NUM_W'(sy);
      zz = 1'b0;
      for (int i = 0; i < swb_pkg::LANES; i++) begin
         vl = (i == swb_pkg::LN_NX || i == swb_pkg::LN_FX) ? vx : vy;
         mag = num[i][swb_pkg::NUM_W-1] ? swb_pkg::NUM_W'(-num[i]) : swb_pkg::NUM_W'(num[i]);
         div_in[i].rem    = '0;
         div_in[i].quo    = '0;
         div_in[i].dvd    = {mag[swb_pkg::MAG_W-1:0], 16'h0000};
         div_in[i].d      = (vl == 16'sd0) ? 16'd1 : (vl[15] ? 16'(-vl) : 16'(vl));
         div_in[i].neg    = num[i][swb_pkg::NUM_W-1] ^ vl[15];
         div_in[i].numneg = num[i][swb_pkg::NUM_W-1];
         div_in[i].vzero  = (vl == 16'sd0);
         zz = zz | ((vl == 16'sd0) && (num[i] == '0));
      end
      hdr_in.ox = (swb_pkg::NUM_W'(sx) <<< 1) + swb_pkg::NUM_W'(sw);
      hdr_in.oy = (swb_pkg::NUM_W'(sy) <<< 1) + swb_pkg::NUM_W'(sh);
      hdr_in.vx = vx;
      hdr_in.vy = vy;
      hdr_in.zz = zz;
   end

   // header shift line
   always_ff @(posedge clock) begin
      if (load[0])
         hdr_ff[0] <= hdr_in;
      for (int k = 1; k < swb_pkg::ST_OUT; k++)
         if (load[k])
            hdr_ff[k] <= hdr_ff[k-1];
   end

   // entry stage and divider stages, three quotient bits each
   always_ff @(posedge clock) begin
      if (load[0])
         div_ff[0] <= div_in;
      for (int k = 1; k <= swb_pkg::DIV_STAGES; k++) begin
         if (load[k]) begin
            for (int i = 0; i < swb_pkg::LANES; i++) begin
               swb_pkg::lane_type l;
               l = div_ff[k-1][i];
               for (int s = 0; s < swb_pkg::DIV_STEPS; s++)
                  l = div_step(l);
               div_ff[k][i] <= l;
            end
         end
      end
   end

   // signed slab times, infinity for zero velocity
   always_comb begin
      logic signed [swb_pkg::T_W-1:0] q;
      for (int i = 0; i < swb_pkg::LANES; i++) begin
         q = $signed({{(swb_pkg::T_W - swb_pkg::DVD_W){1'b0}},
                      div_ff[swb_pkg::DIV_STAGES][i].quo});
         if (div_ff[swb_pkg::DIV_STAGES][i].vzero)
            t_in[i] = div_ff[swb_pkg::DIV_STAGES][i].numneg ? -swb_pkg::T_INF : swb_pkg::T_INF;
         else
            t_in[i] = div_ff[swb_pkg::DIV_STAGES][i].neg ? -q : q;
      end
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_TIME])
         t_ff <= t_in;
   end

   // order near and far per axis
   always_comb begin
      s_in = t_ff;
      if (t_ff[swb_pkg::LN_NX] > t_ff[swb_pkg::LN_FX]) begin
         s_in[swb_pkg::LN_NX] = t_ff[swb_pkg::LN_FX];
         s_in[swb_pkg::LN_FX] = t_ff[swb_pkg::LN_NX];
      end
      if (t_ff[swb_pkg::LN_NY] > t_ff[swb_pkg::LN_FY]) begin
         s_in[swb_pkg::LN_NY] = t_ff[swb_pkg::LN_FY];
         s_in[swb_pkg::LN_FY] = t_ff[swb_pkg::LN_NY];
      end
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_SWAP])
         s_ff <= s_in;
   end

   // slab overlap, entry time and rejection
   always_comb begin
      logic miss;
      logic signed [swb_pkg::T_W-1:0] tfar;
      miss = (s_ff[swb_pkg::LN_NX] > s_ff[swb_pkg::LN_FY]) ||
             (s_ff[swb_pkg::LN_NY] > s_ff[swb_pkg::LN_FX]);
      sel_in.xgt = s_ff[swb_pkg::LN_NX] > s_ff[swb_pkg::LN_NY];
      sel_in.tnear = sel_in.xgt ? s_ff[swb_pkg::LN_NX] : s_ff[swb_pkg::LN_NY];
      tfar = (s_ff[swb_pkg::LN_FX] < s_ff[swb_pkg::LN_FY]) ?
             s_ff[swb_pkg::LN_FX] : s_ff[swb_pkg::LN_FY];
      sel_in.rej = hdr_ff[swb_pkg::ST_SEL-1].zz || miss || tfar[swb_pkg::T_W-1];
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_SEL])
         sel_ff <= sel_in;
   end

   // split products of entry time and velocity
   always_comb begin
      logic signed [swb_pkg::MAG_W:0] tl;
      logic signed [16:0] th;
      tl = $signed({1'b0, sel_ff.tnear[16:0]});
      th = sel_ff.tnear[33:17];
      mul_in.tnear = sel_ff.tnear;
      mul_in.xgt   = sel_ff.xgt;
      mul_in.rej   = sel_ff.rej;
      mul_in.tinf  = (sel_ff.tnear >= swb_pkg::T_INF) || (sel_ff.tnear <= -swb_pkg::T_INF);
      mul_in.pxl   = tl * hdr_ff[swb_pkg::ST_MUL-1].vx;
      mul_in.pxh   = th * hdr_ff[swb_pkg::ST_MUL-1].vx;
      mul_in.pyl   = tl * hdr_ff[swb_pkg::ST_MUL-1].vy;
      mul_in.pyh   = th * hdr_ff[swb_pkg::ST_MUL-1].vy;
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_MUL])
         mul_ff <= mul_in;
   end

   // contact accumulators, origin in 1/32 units scaled to Q.20
   always_comb begin
      acc_in.tnear = mul_ff.tnear;
      acc_in.xgt   = mul_ff.xgt;
      acc_in.rej   = mul_ff.rej;
      acc_in.tinf  = mul_ff.tinf;
      acc_in.accx  = (swb_pkg::ACC_W'(hdr_ff[swb_pkg::ST_ACC-1].ox) <<< 15) +
                     (swb_pkg::ACC_W'(mul_ff.pxh) <<< 17) + swb_pkg::ACC_W'(mul_ff.pxl);
      acc_in.accy  = (swb_pkg::ACC_W'(hdr_ff[swb_pkg::ST_ACC-1].oy) <<< 15) +
                     (swb_pkg::ACC_W'(mul_ff.pyh) <<< 17) + swb_pkg::ACC_W'(mul_ff.pyl);
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_ACC])
         acc_ff <= acc_in;
   end

   // result word: saturation, normals, hit window, rejection zeroes all
   always_comb begin
      logic signed [15:0] vx, vy, cx, cy;
      logic signed [1:0] nx, ny;
      logic signed [23:0] ct;
      logic hit;
      logic tpos;
      vx = hdr_ff[swb_pkg::ST_OUT-1].vx;
      vy = hdr_ff[swb_pkg::ST_OUT-1].vy;
      tpos = !acc_ff.tnear[swb_pkg::T_W-1];
      if (acc_ff.tinf && vx != 16'sd0)
         cx = (tpos == !vx[15]) ? 16'sh7FFF : 16'sh8000;
      else
         cx = sat16(acc_ff.accx);
      if (acc_ff.tinf && vy != 16'sd0)
         cy = (tpos == !vy[15]) ? 16'sh7FFF : 16'sh8000;
      else
         cy = sat16(acc_ff.accy);
      nx = swb_pkg::NRM_NONE;
      ny = swb_pkg::NRM_NONE;
      if (acc_ff.xgt)
         nx = vx[15] ? swb_pkg::NRM_POS : swb_pkg::NRM_NEG;
      else
         ny = vy[15] ? swb_pkg::NRM_POS : swb_pkg::NRM_NEG;
      if (acc_ff.tnear > 42'sd8388607)
         ct = 24'sh7FFFFF;
      else if (acc_ff.tnear < -42'sd8388608)
         ct = 24'sh800000;
      else
         ct = acc_ff.tnear[23:0];
      hit = (acc_ff.tnear >= swb_pkg::T_LOW) && (acc_ff.tnear <= swb_pkg::T_ONE);
      if (acc_ff.rej)
         out_in = '0;
      else
         out_in = {3'b000, ct, ny, nx, cy, cx, hit};
   end

   always_ff @(posedge clock) begin
      if (load[swb_pkg::ST_OUT])
         out_ff <= out_in;
   end

   // a hit always carries exactly one axis normal
   a_hit_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> ((rsp_tdata[34:33] != 2'b00) != (rsp_tdata[36:35] != 2'b00)))
      else $error("hit without a single normal");

   // a hit time lies in the window
   a_hit_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         ($signed(rsp_tdata[60:37]) >= -24'sd6 && $signed(rsp_tdata[60:37]) <= 24'sd65536))
      else $error("hit time outside window");

   // divider remainder of the near x lane stays below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      v_ff[swb_pkg::DIV_STAGES] && !div_ff[swb_pkg::DIV_STAGES][swb_pkg::LN_NX].vzero |->
         div_ff[swb_pkg::DIV_STAGES][swb_pkg::LN_NX].rem <
         div_ff[swb_pkg::DIV_STAGES][swb_pkg::LN_NX].d)
      else $error("divider remainder out of range");

   // input back pressure only when the pipe is full and the output stalled
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready && (&v_ff)))
      else $error("input stalled with room in pipe");

endmodule
